### rtl/sbrc_pkg.sv
// ----------------------------------------------------------------------------
// Snoop bus response collector package
// Shared widths, register indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package sbrc_pkg;

    localparam int MAX_PORTS     = 16;
    localparam int TABLE_ENTRIES = 8;
    localparam int PID_SHIFT     = 48;

    localparam int IDX_W      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W      = $clog2(MAX_PORTS + 1);
    localparam int TYPE_W     = 4;
    localparam int PORT_W     = 4;
    localparam int ADDR_W     = 64;
    localparam int TID_W      = 64;
    localparam int LINE_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_PORT_COUNT   = 2'd0;
    localparam t_cfg_idx CFG_EMPTY_CODE   = 2'd1;
    localparam t_cfg_idx CFG_UPGRADE_CODE = 2'd2;

    localparam logic [CFG_DATA_W-1:0] PORT_COUNT_RST   = 5'd4;
    localparam logic [TYPE_W-1:0]     EMPTY_CODE_RST   = 4'd0;
    localparam logic [TYPE_W-1:0]     UPGRADE_CODE_RST = 4'd3;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_LOOKUP,
        OP_REPLY,
        OP_FORWARD,
        OP_REJECT,
        OP_ALLOC,
        OP_RESPOND,
        OP_BCAST
    } t_dp_op;

    typedef struct packed {
        logic is_mem;
        logic single;
        logic hit;
        logic full;
        logic bcast_done;
    } t_dp_status;

endpackage

### rtl/sbrc_ctrl.sv
// ----------------------------------------------------------------------------
// Snoop bus response collector controller
// Sequences capture, lookup and decision per word; broadcasts new entries.
// ----------------------------------------------------------------------------
module sbrc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  sbrc_pkg::t_dp_status  i_status,
    output sbrc_pkg::t_dp_op      o_op
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_DECIDE,
        S_BCAST
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   n_busy;

    always_comb begin
        n_state = r_state;
        o_op    = sbrc_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_op    = sbrc_pkg::OP_LOAD;
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                o_op    = sbrc_pkg::OP_LOOKUP;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_state = S_IDLE;
                if (i_status.is_mem) begin
                    o_op = sbrc_pkg::OP_REPLY;
                end else if (i_status.single) begin
                    o_op = sbrc_pkg::OP_FORWARD;
                end else if (i_status.hit) begin
                    o_op = sbrc_pkg::OP_RESPOND;
                end else if (i_status.full) begin
                    o_op = sbrc_pkg::OP_REJECT;
                end else begin
                    o_op    = sbrc_pkg::OP_ALLOC;
                    n_state = S_BCAST;
                end
            end
            S_BCAST: begin
                o_op = sbrc_pkg::OP_BCAST;
                if (i_status.bcast_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_busy = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign busy = r_busy;

endmodule

### rtl/sbrc_dpath.sv
// ----------------------------------------------------------------------------
// Snoop bus response collector datapath
// Configuration registers, transaction table, lookup and result register.
// ----------------------------------------------------------------------------
module sbrc_dpath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  sbrc_pkg::t_dp_op                     i_op,
    output sbrc_pkg::t_dp_status                 o_status,
    input  logic                                 i_cfg_we,
    input  logic [sbrc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sbrc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_func,
    input  logic [sbrc_pkg::TYPE_W-1:0]          i_event_type,
    input  logic [sbrc_pkg::ADDR_W-1:0]          i_address,
    input  logic [sbrc_pkg::PORT_W-1:0]          i_requester,
    input  logic [sbrc_pkg::TID_W-1:0]           i_transaction_id,
    input  logic [sbrc_pkg::LINE_W-1:0]          i_line_index,
    output logic                                 o_valid,
    output logic                                 o_to_memory,
    output logic [sbrc_pkg::PORT_W-1:0]          o_dest_port,
    output logic [sbrc_pkg::TYPE_W-1:0]          o_out_type,
    output logic [sbrc_pkg::ADDR_W-1:0]          o_out_address,
    output logic [sbrc_pkg::PORT_W-1:0]          o_out_requester,
    output logic [sbrc_pkg::TID_W-1:0]           o_out_transaction,
    output logic [sbrc_pkg::LINE_W-1:0]          o_out_line,
    output logic                                 o_table_full,
    output logic                                 o_last
);

    localparam int N = sbrc_pkg::TABLE_ENTRIES;

    logic [sbrc_pkg::CFG_DATA_W-1:0] r_port_count;
    logic [sbrc_pkg::TYPE_W-1:0]     r_empty_code;
    logic [sbrc_pkg::TYPE_W-1:0]     r_upgrade_code;

    logic                            r_func;
    logic [sbrc_pkg::TYPE_W-1:0]     r_type;
    logic [sbrc_pkg::ADDR_W-1:0]     r_addr;
    logic [sbrc_pkg::PORT_W-1:0]     r_req;
    logic [sbrc_pkg::TID_W-1:0]      r_tid;
    logic [sbrc_pkg::LINE_W-1:0]     r_line;

    logic [N-1:0]                    r_ent_valid;
    logic [sbrc_pkg::TID_W-1:0]      r_ent_tid   [N];
    logic [sbrc_pkg::TYPE_W-1:0]     r_ent_type  [N];
    logic [sbrc_pkg::ADDR_W-1:0]     r_ent_addr  [N];
    logic [sbrc_pkg::PORT_W-1:0]     r_ent_owner [N];
    logic [sbrc_pkg::LINE_W-1:0]     r_ent_line  [N];
    logic [sbrc_pkg::CNT_W-1:0]      r_ent_cnt   [N];
    logic                            r_ent_hd    [N];

    logic                            r_hit;
    logic                            r_full;
    logic [sbrc_pkg::IDX_W-1:0]      r_hit_idx;
    logic [sbrc_pkg::IDX_W-1:0]      r_free_idx;

    logic [sbrc_pkg::PORT_W-1:0]     r_port;
    logic [sbrc_pkg::PORT_W-1:0]     r_sent;

    logic                            r_valid;
    logic                            r_to_mem;
    logic [sbrc_pkg::PORT_W-1:0]     r_dest;
    logic [sbrc_pkg::TYPE_W-1:0]     r_otype;
    logic [sbrc_pkg::ADDR_W-1:0]     r_oaddr;
    logic [sbrc_pkg::PORT_W-1:0]     r_oreq;
    logic [sbrc_pkg::TID_W-1:0]      r_otid;
    logic [sbrc_pkg::LINE_W-1:0]     r_oline;
    logic                            r_ofull;
    logic                            r_olast;

    logic                            n_valid;
    logic                            n_to_mem;
    logic [sbrc_pkg::PORT_W-1:0]     n_dest;
    logic [sbrc_pkg::TYPE_W-1:0]     n_otype;
    logic [sbrc_pkg::ADDR_W-1:0]     n_oaddr;
    logic [sbrc_pkg::PORT_W-1:0]     n_oreq;
    logic [sbrc_pkg::TID_W-1:0]      n_otid;
    logic [sbrc_pkg::LINE_W-1:0]     n_oline;
    logic                            n_ofull;
    logic                            n_olast;

    logic [sbrc_pkg::CNT_W-1:0]      pc;
    logic [sbrc_pkg::CNT_W-1:0]      pc_m2;
    logic                            lk_hit;
    logic                            lk_full;
    logic [sbrc_pkg::IDX_W-1:0]      lk_hit_idx;
    logic [sbrc_pkg::IDX_W-1:0]      lk_free_idx;
    logic [sbrc_pkg::CNT_W-1:0]      cur_cnt;
    logic [sbrc_pkg::CNT_W-1:0]      cnt_inc;
    logic                            resp_open;
    logic                            resp_done;
    logic                            new_hd;
    logic                            to_proc;
    logic                            bc_emit;
    logic                            bc_last;

    always_comb begin
        if (r_port_count == '0) begin
            pc = sbrc_pkg::CNT_W'(1);
        end else if (sbrc_pkg::CNT_W'(r_port_count) > sbrc_pkg::CNT_W'(sbrc_pkg::MAX_PORTS)) begin
            pc = sbrc_pkg::CNT_W'(sbrc_pkg::MAX_PORTS);
        end else begin
            pc = sbrc_pkg::CNT_W'(r_port_count);
        end
    end

    assign pc_m2 = pc - sbrc_pkg::CNT_W'(2);

    always_comb begin
        lk_hit      = 1'b0;
        lk_full     = 1'b1;
        lk_hit_idx  = '0;
        lk_free_idx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (r_ent_valid[i] && (r_ent_tid[i] == r_tid)) begin
                lk_hit     = 1'b1;
                lk_hit_idx = sbrc_pkg::IDX_W'(i);
            end
            if (!r_ent_valid[i]) begin
                lk_full     = 1'b0;
                lk_free_idx = sbrc_pkg::IDX_W'(i);
            end
        end
    end

    assign cur_cnt   = r_ent_cnt[r_hit_idx];
    assign cnt_inc   = cur_cnt + sbrc_pkg::CNT_W'(1);
    assign resp_open = (cur_cnt < pc);
    assign resp_done = (cnt_inc == pc);
    assign new_hd    = r_ent_hd[r_hit_idx] | (r_type != r_empty_code);
    assign to_proc   = (r_ent_type[r_hit_idx] == r_upgrade_code) | new_hd;
    assign bc_emit   = (r_port != r_req);
    assign bc_last   = (sbrc_pkg::CNT_W'(r_sent) == pc_m2);

    assign o_status.is_mem     = r_func;
    assign o_status.single     = (pc == sbrc_pkg::CNT_W'(1));
    assign o_status.hit        = r_hit;
    assign o_status.full       = r_full;
    assign o_status.bcast_done = bc_emit & bc_last;

    always_comb begin
        n_valid  = 1'b0;
        n_to_mem = 1'b0;
        n_dest   = r_req;
        n_otype  = r_type;
        n_oaddr  = r_addr;
        n_oreq   = r_req;
        n_otid   = r_tid;
        n_oline  = r_line;
        n_ofull  = 1'b0;
        n_olast  = 1'b1;
        case (i_op) inside
            sbrc_pkg::OP_REPLY, sbrc_pkg::OP_FORWARD: begin
                n_valid = 1'b1;
            end
            sbrc_pkg::OP_REJECT: begin
                n_valid = 1'b1;
                n_ofull = 1'b1;
            end
            sbrc_pkg::OP_RESPOND: begin
                n_valid = resp_open & resp_done;
                n_otype = r_ent_type[r_hit_idx];
                n_oaddr = r_ent_addr[r_hit_idx];
                n_oreq  = r_ent_owner[r_hit_idx];
                n_otid  = r_ent_tid[r_hit_idx];
                n_oline = r_ent_line[r_hit_idx];
                if (to_proc) begin
                    n_dest = r_ent_tid[r_hit_idx][sbrc_pkg::PID_SHIFT +: sbrc_pkg::PORT_W];
                end else begin
                    n_to_mem = 1'b1;
                    n_dest   = '0;
                end
            end
            sbrc_pkg::OP_BCAST: begin
                n_valid = bc_emit;
                n_dest  = r_port;
                n_olast = bc_last;
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_count   <= sbrc_pkg::PORT_COUNT_RST;
            r_empty_code   <= sbrc_pkg::EMPTY_CODE_RST;
            r_upgrade_code <= sbrc_pkg::UPGRADE_CODE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sbrc_pkg::CFG_PORT_COUNT:   r_port_count   <= i_cfg_data;
                sbrc_pkg::CFG_EMPTY_CODE:   r_empty_code   <= i_cfg_data[sbrc_pkg::TYPE_W-1:0];
                sbrc_pkg::CFG_UPGRADE_CODE: r_upgrade_code <= i_cfg_data[sbrc_pkg::TYPE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_valid <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_valid <= n_valid;
            case (i_op)
                sbrc_pkg::OP_REPLY: begin
                    if (r_hit) begin
                        r_ent_valid[r_hit_idx] <= 1'b0;
                    end
                end
                sbrc_pkg::OP_ALLOC: begin
                    r_ent_valid[r_free_idx] <= 1'b1;
                end
                sbrc_pkg::OP_RESPOND: begin
                    if (resp_open && resp_done && to_proc) begin
                        r_ent_valid[r_hit_idx] <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            sbrc_pkg::OP_LOAD: begin
                r_func <= i_func;
                r_type <= i_event_type;
                r_addr <= i_address;
                r_req  <= i_requester;
                r_tid  <= i_transaction_id;
                r_line <= i_line_index;
            end
            sbrc_pkg::OP_LOOKUP: begin
                r_hit      <= lk_hit;
                r_full     <= lk_full;
                r_hit_idx  <= lk_hit_idx;
                r_free_idx <= lk_free_idx;
            end
            sbrc_pkg::OP_ALLOC: begin
                r_ent_tid[r_free_idx]   <= r_tid;
                r_ent_type[r_free_idx]  <= r_type;
                r_ent_addr[r_free_idx]  <= r_addr;
                r_ent_owner[r_free_idx] <= r_req;
                r_ent_line[r_free_idx]  <= r_line;
                r_ent_cnt[r_free_idx]   <= sbrc_pkg::CNT_W'(1);
                r_ent_hd[r_free_idx]    <= 1'b0;
                r_port                  <= '0;
                r_sent                  <= '0;
            end
            sbrc_pkg::OP_RESPOND: begin
                if (resp_open) begin
                    r_ent_cnt[r_hit_idx] <= cnt_inc;
                    r_ent_hd[r_hit_idx]  <= new_hd;
                end
            end
            sbrc_pkg::OP_BCAST: begin
                r_port <= r_port + sbrc_pkg::PORT_W'(1);
                if (bc_emit) begin
                    r_sent <= r_sent + sbrc_pkg::PORT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_to_mem <= n_to_mem;
        r_dest   <= n_dest;
        r_otype  <= n_otype;
        r_oaddr  <= n_oaddr;
        r_oreq   <= n_oreq;
        r_otid   <= n_otid;
        r_oline  <= n_oline;
        r_ofull  <= n_ofull;
        r_olast  <= n_olast;
    end

    assign o_valid           = r_valid;
    assign o_to_memory       = r_to_mem;
    assign o_dest_port       = r_dest;
    assign o_out_type        = r_otype;
    assign o_out_address     = r_oaddr;
    assign o_out_requester   = r_oreq;
    assign o_out_transaction = r_otid;
    assign o_out_line        = r_oline;
    assign o_table_full      = r_ofull;
    assign o_last            = r_olast;

endmodule

### rtl/snoop_bus_response_collector_unit.sv
// ----------------------------------------------------------------------------
// Snoop bus response collector
// Broadcasts requests, counts snoop responses and routes completed words.
// ----------------------------------------------------------------------------
// Channel   | Handshake               | Payload
// input     | start, busy             | i_func .. i_line_index
// result    | o_valid (strobe)        | o_to_memory .. o_last
// config    | i_cfg_valid, o_cfg_ready| i_cfg_index, i_cfg_data
//
// A word runs load, lookup and decide; its strobe and busy low then coincide.
// A stored new request is then broadcast, one copy per cycle,
// (port count - 1) copies in all, none in the cycle at the requester's port.
// Lookup of the transaction table has a state of its own and is registered.
// Reset is synchronous and clears the table valid bits and the controller.
// Results are shown for one cycle each and cannot be held off.
module snoop_bus_response_collector_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_func,
    input  logic [sbrc_pkg::TYPE_W-1:0]       i_event_type,
    input  logic [sbrc_pkg::ADDR_W-1:0]       i_address,
    input  logic [sbrc_pkg::PORT_W-1:0]       i_requester,
    input  logic [sbrc_pkg::TID_W-1:0]        i_transaction_id,
    input  logic [sbrc_pkg::LINE_W-1:0]       i_line_index,
    output logic                              o_valid,
    output logic                              o_to_memory,
    output logic [sbrc_pkg::PORT_W-1:0]       o_dest_port,
    output logic [sbrc_pkg::TYPE_W-1:0]       o_out_type,
    output logic [sbrc_pkg::ADDR_W-1:0]       o_out_address,
    output logic [sbrc_pkg::PORT_W-1:0]       o_out_requester,
    output logic [sbrc_pkg::TID_W-1:0]        o_out_transaction,
    output logic [sbrc_pkg::LINE_W-1:0]       o_out_line,
    output logic                              o_table_full,
    output logic                              o_last,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sbrc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sbrc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    sbrc_pkg::t_dp_op     op;
    sbrc_pkg::t_dp_status status;

    assign o_cfg_ready = 1'b1;

    sbrc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (status),
        .o_op     (op)
    );

    sbrc_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_op              (op),
        .o_status          (status),
        .i_cfg_we          (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_func            (i_func),
        .i_event_type      (i_event_type),
        .i_address         (i_address),
        .i_requester       (i_requester),
        .i_transaction_id  (i_transaction_id),
        .i_line_index      (i_line_index),
        .o_valid           (o_valid),
        .o_to_memory       (o_to_memory),
        .o_dest_port       (o_dest_port),
        .o_out_type        (o_out_type),
        .o_out_address     (o_out_address),
        .o_out_requester   (o_out_requester),
        .o_out_transaction (o_out_transaction),
        .o_out_line        (o_out_line),
        .o_table_full      (o_table_full),
        .o_last            (o_last)
    );

endmodule

### rtl/sbrc_chk.sv
// ----------------------------------------------------------------------------
// Snoop bus response collector checker
// Port-level properties of the collector, attached by bind.
// ----------------------------------------------------------------------------
module sbrc_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_valid,
    input logic                          o_to_memory,
    input logic [sbrc_pkg::PORT_W-1:0]   o_dest_port,
    input logic                          o_table_full,
    input logic                          o_last
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted word");

    a_full_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_table_full) |-> (o_last && !o_to_memory))
        else $error("table full result is not a single processor word");

    a_mem_route: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_to_memory) |-> (o_dest_port == '0 && o_last && !o_table_full))
        else $error("memory result carries a bad port or marker");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("result strobe directly after a final word");

endmodule

bind snoop_bus_response_collector_unit sbrc_chk u_sbrc_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_to_memory  (o_to_memory),
    .o_dest_port  (o_dest_port),
    .o_table_full (o_table_full),
    .o_last       (o_last)
);
